>>> hw/rtl/i16mm_pkg.sv
// Shared widths, defaults and the accumulator control struct of the int16 matrix multiply.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package i16mm_pkg;

    localparam int DATA_W           = 16;
    localparam int LANE_W           = 4;
    localparam int COLUMN_W         = 4;
    localparam int GROUP_W          = 2;
    localparam int STEP_W           = 16;
    localparam int DEFAULT_MESH_DIM = 16;
    localparam int OUT_COLS_MAX     = 16;
    localparam int OUT_GROUPS_MAX   = 4;
    localparam int ROWS_PER_GROUP   = 4;

    typedef logic signed [DATA_W-1:0] data_t;

    // Control from the sequencer to the accumulator bank.
    typedef struct packed {
        logic rd_en;      // read one column row of accumulators
        logic mac_en;     // the read belongs to an accumulate sweep
        logic clear_all;  // drop every row back to zero
    } acc_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/int16_matrix_multiply.sv
// Top level of the int16 matrix multiply: step sequencer, drain sequencer and ports.
// Depends on i16mm_pkg, i16mm_operand_buf and i16mm_acc_bank.
`default_nettype none

// Channel   Direction  Handshake              Payload
// -------   ---------  ---------------------  ---------------------------------------------
// input     in         in_valid / in_ready    lane, a_value, b_value
// result    out        out_valid / out_ready  column, row_group, value0..value3, last
// config    in         cfg_wr_en              cfg_wr_data (num_steps, K)
//
// A beat for any lane but the top one is taken at any time. The beat for the top lane
// starts a sweep over the accumulator memory, one column row per cycle with a MESH_DIM-wide
// bank of multipliers; a further top-lane beat is held off until the sweep has issued its
// last column. After the final step of a matrix the drain reads one column row and sends
// it as four beats, and top-lane beats wait for it. Reset clears the row valid bits, so
// the accumulators read as zero at once: there is no clearing pass. A stall on the result
// side holds the drain and nothing else.
module int16_matrix_multiply
    import i16mm_pkg::*;
#(
    parameter int MESH_DIM = DEFAULT_MESH_DIM
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [LANE_W-1:0]   lane,
    input  wire data_t               a_value,
    input  wire data_t               b_value,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [COLUMN_W-1:0]      column,
    output logic [GROUP_W-1:0]       row_group,
    output data_t                    value0,
    output data_t                    value1,
    output data_t                    value2,
    output data_t                    value3,
    output logic                     last,
    input  wire logic                cfg_wr_en,
    input  wire logic [STEP_W-1:0]   cfg_wr_data
);

    localparam int COL_W      = $clog2(MESH_DIM);
    localparam int OUT_COLS   = (MESH_DIM < OUT_COLS_MAX) ? MESH_DIM : OUT_COLS_MAX;
    localparam int OUT_GROUPS = ((MESH_DIM + 3) / 4 < OUT_GROUPS_MAX) ?
                                (MESH_DIM + 3) / 4 : OUT_GROUPS_MAX;
    localparam int OUT_COL_W  = $clog2(OUT_COLS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN_RD,
        ST_DRAIN_OUT
    } state_t;

    state_t               state_reg;
    logic [COL_W-1:0]     sweep_col_reg;
    logic [OUT_COL_W-1:0] drain_col_reg;
    logic [GROUP_W-1:0]   group_reg;
    logic                 out_valid_reg;
    logic                 final_reg;
    logic [STEP_W-1:0]    step_count_reg;
    logic [STEP_W-1:0]    num_steps_reg;

    logic                 trigger_lane;
    logic                 in_accept;
    logic                 trig_accept;
    logic [STEP_W:0]      steps_done;
    logic                 step_final;
    logic                 sweep_last;
    logic                 group_last;
    logic                 col_last;
    logic                 drain_done;
    acc_ctl_t             acc_ctl;
    logic [COL_W-1:0]     rd_col;
    data_t [MESH_DIM-1:0] a_snap;
    data_t                b_sel;
    data_t [MESH_DIM-1:0] rd_row;
    logic                 rd_valid;
    data_t                value_sel [ROWS_PER_GROUP];

    // Only the top lane accumulates, so only its beat has to wait for the memory.
    assign trigger_lane = ({28'd0, lane} == 32'(MESH_DIM - 1));
    assign in_ready     = !trigger_lane || (state_reg == ST_IDLE);
    assign in_accept    = in_valid && in_ready;
    assign trig_accept  = in_accept && trigger_lane;

    // A count of zero behaves as one, since the first completed step already reaches it.
    assign steps_done = {1'b0, step_count_reg} + {{STEP_W{1'b0}}, 1'b1};
    assign step_final = (steps_done >= {1'b0, num_steps_reg});

    assign sweep_last = (sweep_col_reg == COL_W'(MESH_DIM - 1));
    assign group_last = (group_reg == GROUP_W'(OUT_GROUPS - 1));
    assign col_last   = (drain_col_reg == OUT_COL_W'(OUT_COLS - 1));
    assign drain_done = (state_reg == ST_DRAIN_OUT) && out_ready && group_last && col_last;

    assign acc_ctl.rd_en     = (state_reg == ST_SWEEP) || (state_reg == ST_DRAIN_RD);
    assign acc_ctl.mac_en    = (state_reg == ST_SWEEP);
    assign acc_ctl.clear_all = drain_done;
    assign rd_col = (state_reg == ST_SWEEP) ? sweep_col_reg : COL_W'(drain_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_steps_reg <= {{(STEP_W-1){1'b0}}, 1'b1};
        end
        else if (cfg_wr_en)
        begin
            num_steps_reg <= cfg_wr_data;
        end
    end

    // Step and drain sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sweep_col_reg  <= '0;
            drain_col_reg  <= '0;
            group_reg      <= '0;
            out_valid_reg  <= 1'b0;
            final_reg      <= 1'b0;
            step_count_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (trig_accept)
                    begin
                        state_reg      <= ST_SWEEP;
                        sweep_col_reg  <= '0;
                        final_reg      <= step_final;
                        step_count_reg <= step_final ? '0 : steps_done[STEP_W-1:0];
                    end
                end
                ST_SWEEP:
                begin
                    sweep_col_reg <= sweep_col_reg + COL_W'(1);
                    if (sweep_last)
                    begin
                        drain_col_reg <= '0;
                        state_reg     <= final_reg ? ST_DRAIN_RD : ST_IDLE;
                    end
                end
                ST_DRAIN_RD:
                begin
                    state_reg     <= ST_DRAIN_OUT;
                    group_reg     <= '0;
                    out_valid_reg <= 1'b1;
                end
                ST_DRAIN_OUT:
                begin
                    if (out_ready)
                    begin
                        if (group_last)
                        begin
                            out_valid_reg <= 1'b0;
                            if (col_last)
                            begin
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                drain_col_reg <= drain_col_reg + OUT_COL_W'(1);
                                state_reg     <= ST_DRAIN_RD;
                            end
                        end
                        else
                        begin
                            group_reg <= group_reg + GROUP_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Rows of a group that lie past the mesh read as zero.
    always_comb
    begin
        int row_idx;
        for (int i = 0; i < ROWS_PER_GROUP; i++)
        begin
            row_idx      = int'(group_reg) * ROWS_PER_GROUP + i;
            value_sel[i] = '0;
            for (int r = 0; r < MESH_DIM; r++)
            begin
                if (rd_valid && (row_idx == r))
                begin
                    value_sel[i] = rd_row[r];
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign column    = COLUMN_W'(drain_col_reg);
    assign row_group = group_reg;
    assign value0    = value_sel[0];
    assign value1    = value_sel[1];
    assign value2    = value_sel[2];
    assign value3    = value_sel[3];
    assign last      = group_last && col_last;

    i16mm_operand_buf #(
        .MESH_DIM (MESH_DIM)
    ) u_operand_buf (
        .clk         (clk),
        .in_accept   (in_accept),
        .trig_accept (trig_accept),
        .lane        (lane),
        .a_value     (a_value),
        .b_value     (b_value),
        .sel_col     (rd_col),
        .a_snap      (a_snap),
        .b_sel       (b_sel)
    );

    i16mm_acc_bank #(
        .MESH_DIM (MESH_DIM)
    ) u_acc_bank (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (acc_ctl),
        .rd_col   (rd_col),
        .a_snap   (a_snap),
        .b_sel    (b_sel),
        .rd_row   (rd_row),
        .rd_valid (rd_valid)
    );

endmodule

`default_nettype wire

>>> hw/rtl/i16mm_operand_buf.sv
// Operand store of the int16 matrix multiply: per-lane A and B slots and the step snapshot.
// Depends on i16mm_pkg.
`default_nettype none

module i16mm_operand_buf
    import i16mm_pkg::*;
#(
    parameter int MESH_DIM = DEFAULT_MESH_DIM
)
(
    input  wire logic                           clk,
    input  wire logic                           in_accept,
    input  wire logic                           trig_accept,
    input  wire logic [LANE_W-1:0]              lane,
    input  wire data_t                          a_value,
    input  wire data_t                          b_value,
    input  wire logic [$clog2(MESH_DIM)-1:0]    sel_col,
    output data_t     [MESH_DIM-1:0]            a_snap,
    output data_t                               b_sel
);

    data_t a_vec_reg  [MESH_DIM];
    data_t b_vec_reg  [MESH_DIM];
    data_t a_snap_reg [MESH_DIM];
    data_t b_snap_reg [MESH_DIM];

    // Each beat overwrites its lane's slot. The trigger beat also freezes a copy of the
    // whole step, so the next step can fill the slots while the sweep is running.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MESH_DIM; i++)
        begin
            if (in_accept && ({28'd0, lane} == 32'(i)))
            begin
                a_vec_reg[i] <= a_value;
                b_vec_reg[i] <= b_value;
            end
            if (trig_accept)
            begin
                a_snap_reg[i] <= (i == MESH_DIM - 1) ? a_value : a_vec_reg[i];
                b_snap_reg[i] <= (i == MESH_DIM - 1) ? b_value : b_vec_reg[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < MESH_DIM; i++)
        begin
            a_snap[i] = a_snap_reg[i];
        end
    end

    assign b_sel = b_snap_reg[sel_col];

endmodule

`default_nettype wire

>>> hw/rtl/i16mm_acc_bank.sv
// Accumulator memory of the int16 matrix multiply: one row per column of C, read-modify-write.
// Depends on i16mm_pkg.
`default_nettype none

module i16mm_acc_bank
    import i16mm_pkg::*;
#(
    parameter int MESH_DIM = DEFAULT_MESH_DIM
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire acc_ctl_t                       ctl,
    input  wire logic [$clog2(MESH_DIM)-1:0]    rd_col,
    input  wire data_t     [MESH_DIM-1:0]       a_snap,
    input  wire data_t                          b_sel,
    output data_t          [MESH_DIM-1:0]       rd_row,
    output logic                                rd_valid
);

    localparam int COL_W = $clog2(MESH_DIM);

    logic [MESH_DIM*DATA_W-1:0] acc_mem [MESH_DIM];
    logic [MESH_DIM*DATA_W-1:0] rd_data_reg;
    logic [MESH_DIM*DATA_W-1:0] wb_data;
    data_t                      prod_reg [MESH_DIM];
    logic [COL_W-1:0]           wb_col_reg;
    logic                       wb_valid_reg;
    logic                       rd_valid_reg;
    logic [MESH_DIM-1:0]        row_valid_reg;

    // A row whose valid bit is clear reads as zero, which stands in for clearing the memory.
    always_comb
    begin
        for (int r = 0; r < MESH_DIM; r++)
        begin
            rd_row[r] = rd_valid_reg ? data_t'(rd_data_reg[r*DATA_W +: DATA_W]) : data_t'(0);
            wb_data[r*DATA_W +: DATA_W] = rd_row[r] + prod_reg[r];
        end
    end

    assign rd_valid = 1'b1;

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= acc_mem[rd_col];
        end
        if (ctl.mac_en)
        begin
            wb_col_reg <= rd_col;
            for (int r = 0; r < MESH_DIM; r++)
            begin
                prod_reg[r] <= DATA_W'($signed(a_snap[r]) * $signed(b_sel));
            end
        end
        if (wb_valid_reg)
        begin
            acc_mem[wb_col_reg] <= wb_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wb_valid_reg  <= 1'b0;
            rd_valid_reg  <= 1'b0;
            row_valid_reg <= '0;
        end
        else
        begin
            wb_valid_reg <= ctl.mac_en;
            if (ctl.rd_en)
            begin
                rd_valid_reg <= row_valid_reg[rd_col];
            end
            if (ctl.clear_all)
            begin
                row_valid_reg <= '0;
            end
            else if (wb_valid_reg)
            begin
                row_valid_reg[wb_col_reg] <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> sim/int16_matrix_multiply_tb.sv
// Self-checking testbench for int16_matrix_multiply: streams A/B step vectors and checks
// every C beat against an in-bench predictor. Depends on i16mm_pkg and the block's RTL only.
`timescale 1ns / 1ps

module int16_matrix_multiply_tb
    import i16mm_pkg::*;
;

    localparam int MESH         = DEFAULT_MESH_DIM;
    localparam int GROUPS       = MESH / ROWS_PER_GROUP;
    // This leaves ample room for a top-lane sweep to run out after the last beat.
    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_ITEMS  = 450;
    localparam int PHASES        = 6;
    localparam int TIMEOUT_NS    = 2_000_000;

    // Percentages per pacing mode: none, sender idle, receiver stalling, both.
    localparam int SEND_IDLE [4] = '{0, 58, 0, 13};
    localparam int RECV_STALL [4] = '{0, 0, 58, 13};
    // Inner dimension per phase; the all-ones value is cut short mid-matrix.
    localparam logic [STEP_W-1:0] PHASE_K [PHASES] =
        '{16'd1, 16'd2, 16'hFFFF, 16'd3, 16'd1, 16'd2};
    localparam logic [STEP_W-1:0] K_MAX = 16'hFFFF;

    // One result beat: four rows of one column of C.
    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [GROUP_W-1:0]  row_group;
        data_t               value0;
        data_t               value1;
        data_t               value2;
        data_t               value3;
        logic                last;
    } c_beat_t;

    // Holds a copy of the accumulator array and the step vectors, works out the C beats
    // that each operand beat causes, and checks the beats that come out of the block.
    class c_tile_scoreboard;
        data_t             c_acc [MESH][MESH];
        data_t             a_col [MESH];
        data_t             b_row [MESH];
        logic [STEP_W-1:0] steps_done;
        logic [STEP_W-1:0] inner_dim;
        c_beat_t           c_beats_due [$];
        int                faults;
        int                operand_beats;
        int                beats_checked;
        int                tiles_out;

        function new();
            foreach (c_acc[r, c])
                c_acc[r][c] = '0;
            foreach (a_col[i])
            begin
                a_col[i] = '0;
                b_row[i] = '0;
            end
            steps_done    = '0;
            inner_dim     = STEP_W'(1);
            faults        = 0;
            operand_beats = 0;
            beats_checked = 0;
            tiles_out     = 0;
        endfunction

        function void set_inner_dim(logic [STEP_W-1:0] k);
            inner_dim = k;
        endfunction

        function int pending();
            return c_beats_due.size();
        endfunction

        function void note_fault(string what);
            faults++;
            if (faults <= 10)
                $display("[%0t] ERROR: %s", $time, what);
        endfunction

        function void take_operand_beat(logic [LANE_W-1:0] ln, data_t a, data_t b);
            logic signed [2*DATA_W-1:0] prod;
            logic [STEP_W:0]            done;
            c_beat_t                    beat;
            operand_beats++;
            a_col[ln] = a;
            b_row[ln] = b;
            if (ln != LANE_W'(MESH - 1))
                return;
            // The top lane closes the step: add the outer product, wrapping at 16 bits.
            for (int r = 0; r < MESH; r++)
                for (int c = 0; c < MESH; c++)
                begin
                    prod        = (2*DATA_W)'(a_col[r]) * (2*DATA_W)'(b_row[c]);
                    c_acc[r][c] = c_acc[r][c] + data_t'(prod[DATA_W-1:0]);
                end
            done = {1'b0, steps_done} + 1'b1;
            // A zero inner dimension behaves as one; a count already past it ends at once.
            if (done < {1'b0, inner_dim})
            begin
                steps_done = done[STEP_W-1:0];
                return;
            end
            for (int c = 0; c < MESH; c++)
                for (int g = 0; g < GROUPS; g++)
                begin
                    beat.column    = COLUMN_W'(c);
                    beat.row_group = GROUP_W'(g);
                    beat.value0    = c_acc[ROWS_PER_GROUP * g][c];
                    beat.value1    = c_acc[ROWS_PER_GROUP * g + 1][c];
                    beat.value2    = c_acc[ROWS_PER_GROUP * g + 2][c];
                    beat.value3    = c_acc[ROWS_PER_GROUP * g + 3][c];
                    beat.last      = (c == MESH - 1) && (g == GROUPS - 1);
                    c_beats_due.push_back(beat);
                end
            foreach (c_acc[r, c])
                c_acc[r][c] = '0;
            steps_done = '0;
            tiles_out++;
        endfunction

        function void check_c_beat(c_beat_t got);
            c_beat_t want;
            logic    bad;
            if (c_beats_due.size() == 0)
            begin
                note_fault($sformatf("C beat col %0d grp %0d with none expected",
                                     got.column, got.row_group));
                return;
            end
            want = c_beats_due.pop_front();
            beats_checked++;
            bad = (got.column !== want.column) || (got.row_group !== want.row_group)
                || (got.value0 !== want.value0) || (got.value1 !== want.value1)
                || (got.value2 !== want.value2) || (got.value3 !== want.value3)
                || (got.last !== want.last);
            if (bad)
                note_fault({
                    $sformatf("C beat %0d: want col %0d grp %0d %0d %0d %0d %0d last %b,",
                              beats_checked, want.column, want.row_group, want.value0,
                              want.value1, want.value2, want.value3, want.last),
                    $sformatf(" got col %0d grp %0d %0d %0d %0d %0d last %b",
                              got.column, got.row_group, got.value0, got.value1,
                              got.value2, got.value3, got.last)});
        endfunction

        // Anything still queued at the end of the run never arrived.
        function void close_out();
            while (c_beats_due.size() != 0)
            begin
                void'(c_beats_due.pop_front());
                note_fault("expected C beat never arrived");
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [LANE_W-1:0]   lane        = '0;
    data_t               a_value     = '0;
    data_t               b_value     = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [COLUMN_W-1:0] column;
    logic [GROUP_W-1:0]  row_group;
    data_t               value0;
    data_t               value1;
    data_t               value2;
    data_t               value3;
    logic                last;
    logic                cfg_wr_en   = 1'b0;
    logic [STEP_W-1:0]   cfg_wr_data = '0;

    int send_idle_pct   = 0;
    int ready_stall_pct = 0;

    c_tile_scoreboard sb = new();

    data_t corner_vals [4] = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'shFFFF};

    int16_matrix_multiply i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .lane        (lane),
        .a_value     (a_value),
        .b_value     (b_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .column      (column),
        .row_group   (row_group),
        .value0      (value0),
        .value1      (value1),
        .value2      (value2),
        .value3      (value3),
        .last        (last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Operands are mostly random, with a fair share of the signed extremes so that the
    // accumulators wrap often.
    function automatic data_t rand_operand();
        if ($urandom_range(99) < 20)
            return corner_vals[$urandom_range(3)];
        return data_t'($urandom);
    endfunction

    // Presents one operand beat and holds it until the block takes it. Every call begins
    // just after a rising edge; valid stays high across back-to-back beats.
    task automatic send_beat(logic [LANE_W-1:0] ln, data_t a, data_t b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        lane     <= ln;
        a_value  <= a;
        b_value  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.take_operand_beat(ln, a, b);
    endtask

    // A well-formed step: every lane once, in ascending order.
    task automatic send_step();
        for (int l = 0; l < MESH; l++)
            send_beat(LANE_W'(l), rand_operand(), rand_operand());
    endtask

    // A ragged step: lanes in any order, repeats and gaps, which may or may not close
    // with the top lane. The slots keep whatever they last held.
    task automatic send_ragged_step();
        int n;
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
            send_beat(LANE_W'($urandom_range(MESH - 1)), rand_operand(), rand_operand());
        if ($urandom_range(1) == 1)
            send_beat(LANE_W'(MESH - 1), rand_operand(), rand_operand());
    endtask

    // Drops valid, waits for every expected C beat, then lets a sweep with no result
    // run out before anything else is touched.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_inner_dim(logic [STEP_W-1:0] k);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= k;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_inner_dim(k);
    endtask

    // The result side: sample at the edge, check accepted beats, and pick the next ready.
    initial
    begin : c_beat_sink
        c_beat_t seen;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                seen.column    = column;
                seen.row_group = row_group;
                seen.value0    = value0;
                seen.value1    = value1;
                seen.value2    = value2;
                seen.value3    = value3;
                seen.last      = last;
                sb.check_c_beat(seen);
            end
            out_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    initial
    begin : stimulus
        int target;
        int base;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. A zero inner dimension must act as one, so a single step of
        // signed extremes drains straight away. It also writes every lane once, so no
        // later step can read a slot that was never filled.
        write_inner_dim('0);
        for (int l = 0; l < MESH; l++)
            send_beat(LANE_W'(l), corner_vals[l % 4], corner_vals[(l / 4) % 4]);
        settle();

        // A lone top-lane beat reuses whatever the lower slots hold from before.
        send_beat(LANE_W'(MESH - 1), 16'sh7FFF, 16'sh8000);
        settle();

        // A lane overwritten twice before the top lane: only the later value counts.
        send_beat(LANE_W'(3), 16'sh1234, 16'shFEDC);
        send_beat(LANE_W'(3), 16'sh8000, 16'sh7FFF);
        send_beat(LANE_W'(MESH - 1), 16'shFFFF, 16'sh0001);
        settle();

        // Random part: phases with their own inner dimension and pacing mode.
        base = sb.operand_beats;
        for (int p = 0; p < PHASES; p++)
        begin
            send_idle_pct   = SEND_IDLE[p % 4];
            ready_stall_pct = RECV_STALL[p % 4];
            write_inner_dim(PHASE_K[p]);
            if (PHASE_K[p] == K_MAX)
            begin
                // Two steps into a matrix that would never end, then the dimension is
                // lowered to the count already done, so the next step drains it.
                send_step();
                send_step();
                settle();
                write_inner_dim(STEP_W'(2));
            end
            target = base + (p + 1) * RANDOM_ITEMS / PHASES;
            while (sb.operand_beats < target)
            begin
                // Now and then the sender holds off until all of C has come out.
                if ($urandom_range(99) < 4)
                    settle();
                if ($urandom_range(99) < 85)
                    send_step();
                else
                    send_ragged_step();
            end
            settle();
        end

        sb.close_out();
        $display("Covered %0d operand beats and %0d C beats from %0d matrices,",
                 sb.operand_beats, sb.beats_checked, sb.tiles_out);
        $display("K from 0 to %0d, ragged and overwritten lanes, four pacing modes.", K_MAX);
        if (sb.faults == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("Timed out with %0d C beats outstanding", sb.pending());
        $display("Regression FAIL");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/i16mm_pkg.sv
hw/rtl/i16mm_operand_buf.sv
hw/rtl/i16mm_acc_bank.sv
hw/rtl/int16_matrix_multiply.sv
sim/int16_matrix_multiply_tb.sv
